FILE: hdl/token_bucket_table_macros.svh
// Assertion helpers for the token bucket table.
`ifndef TOKEN_BUCKET_TABLE_MACROS_SVH
`define TOKEN_BUCKET_TABLE_MACROS_SVH

`ifndef ASSERT_OFF
`define TBT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TBT_ASSERT_SAME(lbl, ante, cons, msg)
`define TBT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: hdl/tbt_pkg.sv
`timescale 1ns / 1ps

package tbt_pkg;

  localparam int NUM_BUCKETS = 16;
  localparam int IDX_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int CNT_W = $clog2(NUM_BUCKETS + 1);
  // slot is 4 bits wide, so allocate never grants beyond 16
  localparam int ALLOC_N = (NUM_BUCKETS < 16) ? NUM_BUCKETS : 16;

  localparam int SLOT_W = 4;
  localparam int TOK_W = 16;
  localparam int OP_W = 3;
  localparam int ST_W = 2;

  localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
  localparam logic [OP_W-1:0] OP_TAKE    = 3'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 3'd2;
  localparam logic [OP_W-1:0] OP_REL_ALL = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK    = 3'd4;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_BADSLOT = 2'd2;
  localparam logic [ST_W-1:0] ST_SHORT   = 2'd3;

  typedef enum logic {
    ALU_ADD_SAT,
    ALU_SUB
  } alu_op_t;

endpackage

FILE: hdl/tbt_alu.sv
`timescale 1ns / 1ps

// Shared arithmetic unit: saturating refill add, or checked subtract.
module tbt_alu (
  input  tbt_pkg::alu_op_t               op,
  input  logic [tbt_pkg::TOK_W-1:0]      a,
  input  logic [tbt_pkg::TOK_W-1:0]      b,
  input  logic [tbt_pkg::TOK_W-1:0]      lim,
  output logic [tbt_pkg::TOK_W-1:0]      res,
  output logic                           short_fl
);

  logic [tbt_pkg::TOK_W:0] sum;
  logic [tbt_pkg::TOK_W:0] diff;

  assign sum  = {1'b0, a} + {1'b0, b};
  assign diff = {1'b0, a} - {1'b0, b};

  always_comb begin
    short_fl = 1'b0;
    case (op)
      tbt_pkg::ALU_ADD_SAT: begin
        res = (sum >= {1'b0, lim}) ? lim : sum[tbt_pkg::TOK_W-1:0];
      end
      tbt_pkg::ALU_SUB: begin
        // a borrow means too few tokens: hold the count
        short_fl = diff[tbt_pkg::TOK_W];
        res = diff[tbt_pkg::TOK_W] ? a : diff[tbt_pkg::TOK_W-1:0];
      end
      default: begin
        res = a;
      end
    endcase
  end

endmodule

FILE: hdl/token_bucket_table.sv
`timescale 1ns / 1ps

// Channel   Dir  Width  Contents
// s_*       in   56     opcode[2:0] slot[6:3] refill_rate[22:7] burst_limit[38:23]
//                       amount[54:39]
// m_*       out  24     status[1:0] slot_out[5:2] tokens_left[21:6]
//
// One word at a time; s_tready is low while a word is in work. Release, release
// all and bad opcodes go straight to the done state; take reads the bucket and
// then subtracts (a dead slot skips both), allocate probes slots in order, tick
// walks one bucket per cycle via the shared adder and the single memory read port.
// rst clears the valid marks and the control; bucket memories are not cleared.
// A held result does not block the next accept; only its own write-out waits.
module token_bucket_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // opcode, slot, refill_rate, burst_limit, amount
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // status, slot_out, tokens_left
);

  localparam int N  = tbt_pkg::NUM_BUCKETS;
  localparam int IW = tbt_pkg::IDX_W;
  localparam int CW = tbt_pkg::CNT_W;
  localparam int TW = tbt_pkg::TOK_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_TAKE_RD,
    S_TAKE_EX,
    S_TICK,
    S_DONE
  } state_t;

  state_t state;

  logic [N-1:0]  bucket_valid;
  logic [TW-1:0] tokens_mem [N];
  logic [TW-1:0] rate_mem   [N];
  logic [TW-1:0] limit_mem  [N];

  logic [tbt_pkg::OP_W-1:0]   in_op;
  logic [tbt_pkg::SLOT_W-1:0] in_slot;
  logic [TW-1:0]              in_rate;
  logic [TW-1:0]              in_limit;
  logic [TW-1:0]              in_amount;
  logic                       in_slot_ok;
  logic [IW-1:0]              in_idx;

  logic [tbt_pkg::SLOT_W-1:0] slot_r;
  logic [TW-1:0]              rate_r;
  logic [TW-1:0]              limit_r;
  logic [TW-1:0]              amount_r;
  logic                       slot_ok_r;
  logic [IW-1:0]              slot_idx;

  logic [CW-1:0] cnt;
  logic [IW-1:0] cnt_idx;
  logic          rd_pend;
  logic [IW-1:0] rd_idx;
  logic [IW-1:0] rd_addr;
  logic          tick_issue;
  logic [TW-1:0] rd_tokens;
  logic [TW-1:0] rd_rate;
  logic [TW-1:0] rd_limit;

  logic [tbt_pkg::ST_W-1:0]   res_status;
  logic [tbt_pkg::SLOT_W-1:0] res_slot;
  logic [TW-1:0]              res_left;

  tbt_pkg::alu_op_t alu_op;
  logic [TW-1:0]    alu_b;
  logic [TW-1:0]    alu_res;
  logic             alu_short;

  logic          tok_we;
  logic [IW-1:0] tok_waddr;
  logic [TW-1:0] tok_wdata;
  logic          alloc_hit;
  logic          accept;

  assign in_op      = s_tdata[2:0];
  assign in_slot    = s_tdata[6:3];
  assign in_rate    = s_tdata[22:7];
  assign in_limit   = s_tdata[38:23];
  assign in_amount  = s_tdata[54:39];
  assign in_slot_ok = int'(in_slot) < N;
  assign in_idx     = IW'(in_slot);

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign slot_idx = IW'(slot_r);
  assign cnt_idx  = cnt[IW-1:0];

  assign tick_issue = (state == S_TICK) && (cnt < CW'(N));
  assign rd_addr    = (state == S_TICK) ? cnt_idx : slot_idx;
  assign alloc_hit  = (state == S_ALLOC) && (cnt < CW'(tbt_pkg::ALLOC_N))
                      && !bucket_valid[cnt_idx];

  assign alu_op = (state == S_TICK) ? tbt_pkg::ALU_ADD_SAT : tbt_pkg::ALU_SUB;
  assign alu_b  = (state == S_TICK) ? rd_rate : amount_r;

  tbt_alu u_alu (
    .op       (alu_op),
    .a        (rd_tokens),
    .b        (alu_b),
    .lim      (rd_limit),
    .res      (alu_res),
    .short_fl (alu_short)
  );

  always_comb begin
    tok_we    = 1'b0;
    tok_waddr = rd_idx;
    tok_wdata = alu_res;
    case (state)
      S_ALLOC: begin
        tok_we    = alloc_hit;
        tok_waddr = cnt_idx;
        tok_wdata = '0;
      end
      S_TAKE_EX: begin
        tok_we    = !alu_short;
        tok_waddr = slot_idx;
      end
      S_TICK: begin
        tok_we    = rd_pend && bucket_valid[rd_idx];
        tok_waddr = rd_idx;
      end
      default: begin
        tok_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tok_we) begin
      tokens_mem[tok_waddr] <= tok_wdata;
    end
    if (alloc_hit) begin
      rate_mem[cnt_idx]  <= rate_r;
      limit_mem[cnt_idx] <= limit_r;
    end
    rd_tokens <= tokens_mem[rd_addr];
    rd_rate   <= rate_mem[rd_addr];
    rd_limit  <= limit_mem[rd_addr];
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_idx <= cnt_idx;
    if (accept) begin
      slot_r    <= in_slot;
      rate_r    <= in_rate;
      limit_r   <= in_limit;
      amount_r  <= in_amount;
      slot_ok_r <= in_slot_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      bucket_valid <= '0;
      cnt          <= '0;
      rd_pend      <= 1'b0;
      m_tvalid     <= 1'b0;
      m_tdata      <= '0;
      res_status   <= tbt_pkg::ST_OK;
      res_slot     <= '0;
      res_left     <= '0;
    end else begin
      rd_pend <= tick_issue;
      // the done state reloads the output itself
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_status <= tbt_pkg::ST_OK;
            res_slot   <= in_slot;
            res_left   <= '0;
            cnt        <= '0;
            state      <= S_DONE;
            case (in_op)
              tbt_pkg::OP_ALLOC: begin
                state <= S_ALLOC;
              end
              tbt_pkg::OP_TAKE: begin
                if (in_slot_ok && bucket_valid[in_idx]) begin
                  state <= S_TAKE_RD;
                end else begin
                  res_status <= tbt_pkg::ST_BADSLOT;
                end
              end
              tbt_pkg::OP_RELEASE: begin
                if (in_slot_ok && bucket_valid[in_idx]) begin
                  bucket_valid[in_idx] <= 1'b0;
                end else begin
                  res_status <= tbt_pkg::ST_BADSLOT;
                end
              end
              tbt_pkg::OP_REL_ALL: begin
                bucket_valid <= '0;
              end
              tbt_pkg::OP_TICK: begin
                state <= S_TICK;
              end
              default: begin
                res_status <= tbt_pkg::ST_BADSLOT;
              end
            endcase
          end
        end
        S_ALLOC: begin
          if (cnt == CW'(tbt_pkg::ALLOC_N)) begin
            res_status <= tbt_pkg::ST_FULL;
            state      <= S_DONE;
          end else if (alloc_hit) begin
            bucket_valid[cnt_idx] <= 1'b1;
            res_slot <= tbt_pkg::SLOT_W'(cnt);
            state    <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_TAKE_RD: begin
          state <= S_TAKE_EX;
        end
        S_TAKE_EX: begin
          res_left <= alu_res;
          if (alu_short) begin
            res_status <= tbt_pkg::ST_SHORT;
          end
          state <= S_DONE;
        end
        S_TICK: begin
          // reads run one bucket ahead of the adder
          if (tick_issue) begin
            cnt <= cnt + 1'b1;
          end
          if (rd_pend && bucket_valid[rd_idx] && slot_ok_r && rd_idx == slot_idx) begin
            res_left <= alu_res;
          end
          if (!tick_issue) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, res_left, res_slot, res_status};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "token_bucket_table_macros.svh"

  `TBT_ASSERT_SAME(a_full_means_all_used, state == S_ALLOC && cnt == CW'(tbt_pkg::ALLOC_N), &bucket_valid[tbt_pkg::ALLOC_N-1:0], "allocate reported full with a free slot")
  `TBT_ASSERT_SAME(a_refill_within_limit, state == S_TICK && tok_we, alu_res <= rd_limit, "refill exceeds burst limit")
  `TBT_ASSERT_NEXT(a_release_all_clears, accept && in_op == tbt_pkg::OP_REL_ALL, bucket_valid == '0, "release all left a valid bucket")
  `TBT_ASSERT_SAME(a_read_only_in_tick, rd_pend, state == S_TICK, "refill read outside tick walk")

endmodule
